[hw/rtl/lcf_pkg.sv]
package lcf_pkg;

  // Table geometry.
  localparam int MATERIAL_COUNT = 15;
  localparam int TBL_AW         = $clog2(MATERIAL_COUNT);
  localparam int ELEMS          = 9;
  localparam int ELEM_IW        = $clog2(ELEMS);
  localparam int MAT_W          = 4;
  localparam int MAT_CMP_W      = 8;

  // Field widths.
  localparam int ELEM_W = 24;
  localparam int CHG_W  = 32;
  localparam int INV_W  = 40;
  localparam int OUT_W  = 48;

  // Internal arithmetic widths.
  localparam int S2_W   = 34;   // charge - 2*pz, signed
  localparam int S2M_W  = 33;   // magnitude of that
  localparam int PRD_W  = 48;   // element products
  localparam int CF_W   = 49;   // cofactor, signed
  localparam int CM_W   = 48;   // cofactor magnitude
  localparam int AM_W   = 73;   // |s2| * inv magnitude
  localparam int D_W    = 74;   // determinant, signed
  localparam int NUM_W  = 121;  // dividend magnitude
  localparam int Q_BITS = 49;   // quotient bits, top bit flags overflow
  localparam int DEN_SH = 17;
  localparam int CMP_W  = D_W + DEN_SH + Q_BITS - 1;

  // Command codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Register indexes.
  localparam logic REG_COMPENSATE = 1'b0;
  localparam logic REG_INV_VACUUM = 1'b1;

  localparam logic [INV_W-1:0] INV_VACUUM_RESET = 40'd112940906737;
  localparam logic signed [ELEM_W-1:0] ONE_Q12 = 24'sd4096;

  localparam logic [OUT_W-1:0] MAG_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] MAG_NEG_MAX = 48'h8000_0000_0000;

  typedef logic [ELEMS-1:0][ELEM_W-1:0] row_t;

  // Work item handed from the arithmetic front end to the divider.
  typedef struct packed {
    logic                        dzero;
    logic [2:0]                  neg;
    logic [D_W-1:0]              dmag;
    logic [2:0][NUM_W-1:0]       rem;
    logic [2:0][Q_BITS-1:0]      quot;
  } lcf_div_t;

endpackage

[hw/rtl/layered_cell_field_from_permittivity.sv]
// Static field of one cell of a layered film. Each input transaction is either a
// write of one element of a material's 3x3 relative permittivity tensor (no result)
// or a compute of E = (0.5*charge - pz) * inv_vacuum * (third column of the inverse
// tensor), one result transaction with each component truncated toward zero and
// saturated to 48 bits. Material 0, and any material above the table size, is
// vacuum. A zero determinant raises singular with zero fields; compensate mode
// zeroes the fields. The datapath is a 57-stage pipeline (7 arithmetic stages, a
// 49-stage one-bit-per-stage divider and the output register), and one transaction
// is accepted every cycle while the pipeline is not held. The whole pipeline holds
// only when the output register is full and not taken. A table write takes effect
// for a compute accepted in the next cycle. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
module layered_cell_field_from_permittivity (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration writes.
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [lcf_pkg::INV_W-1:0]         cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [lcf_pkg::MAT_W-1:0]         material_type,
  input  logic [3:0]                        tensor_element,
  input  logic signed [lcf_pkg::ELEM_W-1:0] permittivity_value,
  input  logic signed [lcf_pkg::CHG_W-1:0]  layer_charge,
  input  logic signed [lcf_pkg::CHG_W-1:0]  polarization_z,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lcf_pkg::OUT_W-1:0]  field_x,
  output logic signed [lcf_pkg::OUT_W-1:0]  field_y,
  output logic signed [lcf_pkg::OUT_W-1:0]  field_z,
  output logic                              singular
);
  import lcf_pkg::*;

  logic              compensate_mode;
  logic [INV_W-1:0]  inv_vacuum_permittivity;

  logic              adv;
  logic              accept;
  logic              mat_in_table;
  logic              tbl_wr;
  logic              take;
  logic [TBL_AW-1:0] tbl_addr;
  row_t              tbl_row;

  logic              front_valid;
  lcf_div_t          front_data;
  logic              div_valid;
  lcf_div_t          div_data;

  logic [OUT_W-1:0]  mag   [3];
  logic [OUT_W-1:0]  fld   [3];

  // The pipeline moves as one; it stops only when a finished result is not taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  assign mat_in_table = (material_type != '0) &&
                        ({4'd0, material_type} <= MAT_CMP_W'(MATERIAL_COUNT));
  assign tbl_addr     = TBL_AW'(material_type - 4'd1);

  // Writes to vacuum, to an unknown material or to an element past the tensor
  // are dropped.
  assign tbl_wr = accept && (command == CMD_WRITE) && mat_in_table &&
                  (tensor_element <= 4'(ELEMS - 1));
  assign take   = accept && (command == CMD_COMPUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      compensate_mode         <= 1'b0;
      inv_vacuum_permittivity <= INV_VACUUM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COMPENSATE: compensate_mode         <= cfg_data[0];
        REG_INV_VACUUM: inv_vacuum_permittivity <= cfg_data;
        default: ;
      endcase
    end
  end

  lcf_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_addr),
    .wr_elem (ELEM_IW'(tensor_element)),
    .wr_data (permittivity_value),
    .rd_en   (take && mat_in_table),
    .rd_addr (tbl_addr),
    .rd_row  (tbl_row)
  );

  lcf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .take           (take),
    .vacuum         (!mat_in_table),
    .layer_charge   (layer_charge),
    .polarization_z (polarization_z),
    .row            (tbl_row),
    .inv_vac        (inv_vacuum_permittivity),
    .div_valid      (front_valid),
    .div_data       (front_data)
  );

  lcf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  // Saturate each quotient to the signed 48-bit range and apply its sign.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (div_data.neg[k]) begin
        if (div_data.quot[k][Q_BITS-1] || (div_data.quot[k][OUT_W-1:0] > MAG_NEG_MAX)) begin
          mag[k] = MAG_NEG_MAX;
        end else begin
          mag[k] = div_data.quot[k][OUT_W-1:0];
        end
        fld[k] = OUT_W'(~mag[k] + 1'b1);
      end else begin
        if (div_data.quot[k][Q_BITS-1] || (div_data.quot[k][OUT_W-1:0] > MAG_POS_MAX)) begin
          mag[k] = MAG_POS_MAX;
        end else begin
          mag[k] = div_data.quot[k][OUT_W-1:0];
        end
        fld[k] = mag[k];
      end
      if (div_data.dzero || compensate_mode) begin
        fld[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      field_x  <= $signed(fld[0]);
      field_y  <= $signed(fld[1]);
      field_z  <= $signed(fld[2]);
      singular <= div_data.dzero;
    end
  end

endmodule

[hw/rtl/lcf_table.sv]
module lcf_table (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [lcf_pkg::TBL_AW-1:0]        wr_addr,
  input  logic [lcf_pkg::ELEM_IW-1:0]       wr_elem,
  input  logic [lcf_pkg::ELEM_W-1:0]        wr_data,
  input  logic                              rd_en,
  input  logic [lcf_pkg::TBL_AW-1:0]        rd_addr,
  output lcf_pkg::row_t                     rd_row
);
  import lcf_pkg::*;

  // One row per material, written one element at a time.
  row_t mem [MATERIAL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_elem] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/lcf_front.sv]
module lcf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              take,
  input  logic                              vacuum,
  input  logic signed [lcf_pkg::CHG_W-1:0]  layer_charge,
  input  logic signed [lcf_pkg::CHG_W-1:0]  polarization_z,
  input  lcf_pkg::row_t                     row,
  input  logic [lcf_pkg::INV_W-1:0]         inv_vac,
  output logic                              div_valid,
  output lcf_pkg::lcf_div_t                 div_data
);
  import lcf_pkg::*;

  logic [6:1] v;

  // Stage 1.
  logic                    vac1;
  logic signed [S2_W-1:0]  s2_1;
  // Stage 2.
  logic signed [PRD_W-1:0]  p2 [6];
  logic signed [ELEM_W-1:0] ez2 [3];
  logic                     s2neg2;
  logic [S2M_W-1:0]         s2abs2;
  // Stage 3.
  logic signed [CF_W-1:0]   c3 [3];
  logic signed [ELEM_W-1:0] ez3 [3];
  logic [S2M_W+19:0]        alo3;
  logic [S2M_W+19:0]        ahi3;
  logic                     s2neg3;
  // Stage 4.
  logic [AM_W-1:0]          amag4;
  logic [CM_W-1:0]          cabs4 [3];
  logic [2:0]               cneg4;
  logic signed [ELEM_W+25:0] dl4 [3];
  logic signed [ELEM_W+23:0] dh4 [3];
  logic                     s2neg4;
  // Stage 5.
  logic signed [D_W-1:0]    t5 [3];
  logic [48:0]              np5 [3][3][2];
  logic [2:0]               cneg5;
  logic                     s2neg5;
  // Stage 6.
  logic signed [D_W-1:0]    d6;
  logic [72:0]              r6 [3][3];
  logic [2:0]               cneg6;
  logic                     s2neg6;

  logic signed [ELEM_W-1:0] e [ELEMS];
  logic [24:0]              ach [3];
  logic [23:0]              cch [3][2];

  always_comb begin
    for (int i = 0; i < ELEMS; i++) begin
      if (vac1) begin
        e[i] = (i == 0 || i == 4 || i == 8) ? ONE_Q12 : '0;
      end else begin
        e[i] = $signed(row[i]);
      end
    end
    ach[0] = amag4[24:0];
    ach[1] = amag4[49:25];
    ach[2] = 25'(amag4[72:50]);
    for (int k = 0; k < 3; k++) begin
      cch[k][0] = cabs4[k][23:0];
      cch[k][1] = cabs4[k][47:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      div_valid <= 1'b0;
    end else if (adv) begin
      v         <= {v[5:1], take};
      div_valid <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: source charge term.
      vac1 <= vacuum;
      s2_1 <= S2_W'(layer_charge) - (S2_W'(polarization_z) <<< 1);

      // Stage 2: cofactor products.
      p2[0]  <= e[1] * e[5];
      p2[1]  <= e[2] * e[4];
      p2[2]  <= e[2] * e[3];
      p2[3]  <= e[0] * e[5];
      p2[4]  <= e[0] * e[4];
      p2[5]  <= e[1] * e[3];
      ez2[0] <= e[6];
      ez2[1] <= e[7];
      ez2[2] <= e[8];
      s2neg2 <= s2_1[S2_W-1];
      s2abs2 <= s2_1[S2_W-1] ? S2M_W'(-s2_1) : S2M_W'(s2_1);

      // Stage 3: cofactors and the split charge-by-inverse-permittivity product.
      c3[0]  <= CF_W'(p2[0]) - CF_W'(p2[1]);
      c3[1]  <= CF_W'(p2[2]) - CF_W'(p2[3]);
      c3[2]  <= CF_W'(p2[4]) - CF_W'(p2[5]);
      ez3    <= ez2;
      alo3   <= s2abs2 * inv_vac[19:0];
      ahi3   <= s2abs2 * inv_vac[39:20];
      s2neg3 <= s2neg2;

      // Stage 4: determinant partial products and cofactor magnitudes.
      amag4 <= (AM_W'(ahi3) << 20) + AM_W'(alo3);
      for (int k = 0; k < 3; k++) begin
        cneg4[k] <= c3[k][CF_W-1];
        cabs4[k] <= c3[k][CF_W-1] ? CM_W'(-c3[k]) : CM_W'(c3[k]);
        dl4[k]   <= ez3[k] * $signed({1'b0, c3[k][24:0]});
        dh4[k]   <= ez3[k] * $signed(c3[k][48:25]);
      end
      s2neg4 <= s2neg3;

      // Stage 5: determinant terms and the dividend partial products.
      for (int k = 0; k < 3; k++) begin
        t5[k] <= (D_W'(dh4[k]) <<< 25) + D_W'(dl4[k]);
        for (int j = 0; j < 3; j++) begin
          for (int i = 0; i < 2; i++) begin
            np5[k][j][i] <= ach[j] * cch[k][i];
          end
        end
      end
      cneg5  <= cneg4;
      s2neg5 <= s2neg4;

      // Stage 6: determinant sum and first dividend reduction.
      d6 <= t5[0] + t5[1] + t5[2];
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          r6[k][j] <= 73'(np5[k][j][0]) + (73'(np5[k][j][1]) << 24);
        end
      end
      cneg6  <= cneg5;
      s2neg6 <= s2neg5;

      // Stage 7: magnitudes and signs for the divider.
      div_data.dzero <= (d6 == '0);
      div_data.dmag  <= d6[D_W-1] ? D_W'(-d6) : D_W'(d6);
      for (int k = 0; k < 3; k++) begin
        div_data.neg[k] <= s2neg6 ^ cneg6[k] ^ d6[D_W-1];
        div_data.rem[k] <= NUM_W'(r6[k][0]) + (NUM_W'(r6[k][1]) << 25)
                         + (NUM_W'(r6[k][2]) << 50);
      end
      div_data.quot <= '0;
    end
  end

endmodule

[hw/rtl/lcf_div.sv]
module lcf_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  lcf_pkg::lcf_div_t    in_data,
  output logic                 out_valid,
  output lcf_pkg::lcf_div_t    out_data
);
  import lcf_pkg::*;

  // One quotient bit per stage, most significant first.
  logic     vld [Q_BITS];
  lcf_div_t st  [Q_BITS];

  for (genvar g = 0; g < Q_BITS; g++) begin : g_stage
    localparam int BIT = Q_BITS - 1 - g;
    localparam int SH  = DEN_SH + BIT;

    logic     vin;
    lcf_div_t din;
    lcf_div_t dout;
    logic [CMP_W-1:0] den_sh;
    logic [CMP_W-1:0] rem_ext;

    if (g == 0) begin : g_first
      assign vin = in_valid;
      assign din = in_data;
    end else begin : g_next
      assign vin = vld[g-1];
      assign din = st[g-1];
    end

    always_comb begin
      dout   = din;
      den_sh = CMP_W'(din.dmag) << SH;
      for (int k = 0; k < 3; k++) begin
        rem_ext = CMP_W'(din.rem[k]);
        if (rem_ext >= den_sh) begin
          dout.rem[k]       = NUM_W'(rem_ext - den_sh);
          dout.quot[k][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv) begin
        vld[g] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[g] <= dout;
      end
    end
  end

  assign out_valid = vld[Q_BITS-1];
  assign out_data  = st[Q_BITS-1];

endmodule

[hw/rtl/lcf_checker.sv]
module lcf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [lcf_pkg::OUT_W-1:0]  field_x,
  input logic signed [lcf_pkg::OUT_W-1:0]  field_y,
  input logic signed [lcf_pkg::OUT_W-1:0]  field_z,
  input logic                              singular
);
  import lcf_pkg::*;

  // A result that is not taken holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(field_x) && $stable(field_y)
      && $stable(field_z) && $stable(singular))
    else $error("result changed while stalled");

  // A singular tensor never reports a field.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> field_x == '0 && field_y == '0 && field_z == '0)
    else $error("singular result with nonzero field");

  // An empty output never stalls the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind layered_cell_field_from_permittivity lcf_checker u_lcf_checker (.*);
